### rtl/core/pta_pkg.sv
// ----------------------------------------------------------------------------
// PID turn-to-angle package
// Types, register map and fixed-point constants of the turn controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pta_pkg;

  localparam int unsigned TICK_MS = 15;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned ERR_W   = ANGLE_W + 1;
  localparam int unsigned DERIV_W = ERR_W + 1;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned STILL_W = 17;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned TOUT_W  = 16;
  localparam int unsigned DRIVE_W = 13;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned PROD_W  = DERIV_W + GAIN_W + 1;
  localparam int unsigned LO_W    = PROD_W + 2;

  localparam logic [STILL_W-1:0] STILL_MAX  = '1;
  localparam logic [ERR_W-1:0]   ONE_DEGREE = ERR_W'(256);
  localparam int                 DRIVE_LIMIT = 3072;

  localparam logic [ANGLE_W-1:0] TARGET_RST = '0;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST = GAIN_W'(7549747);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = GAIN_W'(1007);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = GAIN_W'(8388608);
  localparam logic [TOUT_W-1:0]  TOUT_RST   = TOUT_W'(15);

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_TOUT   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    logic                      operation;
    logic signed [ANGLE_W-1:0] measured_angle;
    logic                      is_still;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done_res;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/pid_turn_to_angle.sv
// ----------------------------------------------------------------------------
// PID turn-to-angle controller
// Updates error, integral and still time per sample and forms a saturated
// drive voltage toward the configured heading.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                              Direction
//   ------    -----------------------------------  ---------
//   in        in_valid_i, in_stall_o, in_data_i    sink
//   out       out_valid_o, out_stall_i, out_data_o source
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One transfer is accepted per cycle while in_stall_o is low; its result is registered in each stage in turn.
// Controller state is updated in the first stage, so samples follow back to
// back; the later stages form the gain products and the rounded sum.
// A stall on the output holds each full stage behind it up to the first empty one.
// Reset restores the register defaults and leaves the controller finished.
`default_nettype none

module pid_turn_to_angle #(
  parameter int unsigned TickMs = pta_pkg::TICK_MS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pta_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pta_pkg::DATA_W-1:0]  pwdata,
  output logic      [pta_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire pta_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output pta_pkg::out_t                    out_data_o
);
  import pta_pkg::*;

  localparam int unsigned StillAddW = $clog2(2 ** STILL_W + TickMs);

  logic [ANGLE_W-1:0] target_q;
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [TOUT_W-1:0]  tout_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
      tout_q   <= TOUT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TARGET: target_q <= pwdata[ANGLE_W-1:0];
        REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
        REG_TOUT:   tout_q   <= pwdata[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET: prdata = DATA_W'(target_q);
      REG_GAIN_P: prdata = DATA_W'(gain_p_q);
      REG_GAIN_I: prdata = DATA_W'(gain_i_q);
      REG_GAIN_D: prdata = DATA_W'(gain_d_q);
      REG_TOUT:   prdata = DATA_W'(tout_q);
      default:    prdata = '0;
    endcase
  end

  function automatic logic loop_continues(input logic [ERR_W-1:0]   mag,
                                          input logic [STILL_W-1:0] still,
                                          input logic [TOUT_W-1:0]  tout);
    logic far;
    logic wait_still;
    far        = (tout == '0) && (mag > ONE_DEGREE);
    wait_still = (mag != '0) && (still <= STILL_W'(tout));
    return far || wait_still;
  endfunction

  // Stage valids and handshake.
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic take1, take2, take3, take4, take5;

  assign take5      = !out_valid_q || !out_stall_i;
  assign take4      = !v4_q || take5;
  assign take3      = !v3_q || take4;
  assign take2      = !v2_q || take3;
  assign take1      = !v1_q || take2;
  assign in_stall_o = !take1;

  // Stage 1: input register and controller state update.
  in_t                       in_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [ERR_W-1:0]   last_q;
  logic [STILL_W-1:0]        still_q;
  logic                      finished_q;

  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          mag;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [SUM_W:0]     acc;
  logic signed [SUM_W-1:0]   acc_sat;
  logic [StillAddW-1:0]      still_add;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [ERR_W-1:0]   last_d;
  logic [STILL_W-1:0]        still_d;
  logic                      finished_d;
  logic                      active;
  logic                      done1;

  assign err   = $signed({target_q[ANGLE_W-1], target_q})
               - $signed({in_q.measured_angle[ANGLE_W-1], in_q.measured_angle});
  assign mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign deriv = DERIV_W'(err) - DERIV_W'(last_q);
  assign acc   = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err);
  assign still_add = StillAddW'(still_q) + StillAddW'(TickMs);
  assign active    = (in_q.operation == OP_TICK) && !finished_q;

  always_comb begin
    if (acc[SUM_W] != acc[SUM_W-1]) begin
      acc_sat = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc[SUM_W-1:0];
    end
  end

  always_comb begin
    sum_d      = sum_q;
    last_d     = last_q;
    still_d    = still_q;
    finished_d = finished_q;
    if (in_q.operation == OP_START) begin
      sum_d      = SUM_W'(err);
      last_d     = err;
      still_d    = '0;
      finished_d = !loop_continues(mag, '0, tout_q);
    end else if (!finished_q) begin
      sum_d  = (err == '0) ? '0 : acc_sat;
      last_d = err;
      if (in_q.is_still) begin
        still_d = (still_add > StillAddW'(STILL_MAX)) ? STILL_MAX
                                                       : still_add[STILL_W-1:0];
      end
      finished_d = !loop_continues(mag, still_d, tout_q);
    end
    done1 = finished_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      last_q     <= '0;
      still_q    <= '0;
      finished_q <= 1'b1;
    end else if (v1_q && take2) begin
      sum_q      <= sum_d;
      last_q     <= last_d;
      still_q    <= still_d;
      finished_q <= finished_d;
    end
  end

  // Stage 2: error terms for the gain products.
  logic signed [ERR_W-1:0]   err2_q;
  logic signed [DERIV_W-1:0] deriv2_q;
  logic signed [SUM_W-1:0]   sum2_q;
  logic                      zero2_q, done2_q;

  // Stage 3: gain products.
  logic signed [PROD_W-1:0]  pp3_q, dp3_q, lp3_q, hp3_q;
  logic                      zero3_q, done3_q;
  logic signed [PROD_W-1:0]  pp_d, dp_d, lp_d, hp_d;

  assign pp_d = PROD_W'(err2_q) * PROD_W'($signed({1'b0, gain_p_q}));
  assign dp_d = PROD_W'(deriv2_q) * PROD_W'($signed({1'b0, gain_d_q}));
  assign lp_d = PROD_W'($signed({1'b0, sum2_q[FRAC_W-1:0]}))
              * PROD_W'($signed({1'b0, gain_i_q}));
  assign hp_d = PROD_W'($signed(sum2_q[SUM_W-1:FRAC_W]))
              * PROD_W'($signed({1'b0, gain_i_q}));

  // Stage 4: fractional sum with rounding offset.
  logic signed [LO_W-1:0]    lo4_q;
  logic signed [PROD_W-1:0]  hp4_q;
  logic                      zero4_q, done4_q;
  logic signed [LO_W-1:0]    lo_d;

  assign lo_d = LO_W'(pp3_q) + LO_W'(dp3_q) + LO_W'(lp3_q)
              + LO_W'(2 ** (FRAC_W - 1));

  // Result stage: whole-part sum and saturation.
  out_t                      out_q;
  out_t                      out_d;
  logic signed [LO_W-1:0]    total;

  assign total = LO_W'(hp4_q) + (lo4_q >>> FRAC_W);

  always_comb begin
    out_d.done_res = done4_q;
    if (zero4_q) begin
      out_d.drive = '0;
    end else if (total > LO_W'(DRIVE_LIMIT)) begin
      out_d.drive = DRIVE_W'(DRIVE_LIMIT);
    end else if (total < -LO_W'(DRIVE_LIMIT)) begin
      out_d.drive = -DRIVE_W'(DRIVE_LIMIT);
    end else begin
      out_d.drive = total[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take1) begin
        v1_q <= in_valid_i;
      end
      if (take2) begin
        v2_q <= v1_q;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
      if (take4) begin
        v4_q <= v3_q;
      end
      if (take5) begin
        out_valid_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1) begin
      in_q <= in_data_i;
    end
    if (take2) begin
      err2_q   <= err;
      deriv2_q <= deriv;
      sum2_q   <= sum_d;
      zero2_q  <= !active;
      done2_q  <= done1;
    end
    if (take3) begin
      pp3_q   <= pp_d;
      dp3_q   <= dp_d;
      lp3_q   <= lp_d;
      hp3_q   <= hp_d;
      zero3_q <= zero2_q;
      done3_q <= done2_q;
    end
    if (take4) begin
      lo4_q   <= lo_d;
      hp4_q   <= hp3_q;
      zero4_q <= zero3_q;
      done4_q <= done3_q;
    end
    if (take5) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
